// File: rtl/csvt_pkg.sv
// Package for the CSV field tokenizer: word types, status codes, register
// indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package csvt_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG  = 2'd1;
  localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_SEPARATOR = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_PROTECT   = 1'd1;

  localparam logic [ByteW-1:0] SEPARATOR_RESET = 8'd44;
  localparam logic [ByteW-1:0] PROTECT_RESET   = 8'd34;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_line;
  } csvt_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    logic             field_end;
    logic             row_end;
    logic [7:0]       column_index;
    logic [1:0]       status;
  } csvt_result_t;

endpackage

// File: rtl/csv_field_tokenizer_core.sv
// Top level of the CSV field tokenizer: input register, parser, result
// register and configuration registers. Depends on csvt_pkg and submodules.
`timescale 1ns / 1ps

// Splits a CSV byte stream into fields, one word per clock: a word (a text
// byte or an end-of-line mark) enters the input register, the parser decides
// it combinationally and writes at most one result into the result
// register, and the sustained rate is one word per cycle. The
// input stalls only while a word waits on a full result register that the
// sink stalls; a held word waits there whether or not it yields a result (an
// opening quote, the first byte of a doubled quote). Register 0 is the
// separator (reset ','), register 1 the protect byte (reset '"'); write them
// only while idle. The first row sets the column count (at most MAX_COLUMNS);
// a later row of other length, or a row over the limit, yields one error
// result and the block then stays silent until reset. column_index is the
// low 8 bits of the column.
module csv_field_tokenizer_core #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [csvt_pkg::ByteW-1:0]    in_byte_i,
  input  logic                          end_of_line_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [csvt_pkg::ByteW-1:0]    out_byte_o,
  output logic                          byte_valid_o,
  output logic                          field_end_o,
  output logic                          row_end_o,
  output logic [7:0]                    column_index_o,
  output logic [1:0]                    status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [csvt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [csvt_pkg::ByteW-1:0]    cfg_data_i
);
  import csvt_pkg::*;

  logic [ByteW-1:0] separator_q;
  logic [ByteW-1:0] protect_q;
  csvt_item_t       in_item;
  csvt_item_t       item;
  logic             item_valid;
  logic             free;
  logic             fire;
  logic             has_result;
  csvt_result_t     result;
  csvt_result_t     out_result;

  assign cfg_ready_o = 1'b1;
  assign in_item     = '{in_byte: in_byte_i, end_of_line: end_of_line_i};
  assign fire        = item_valid && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      separator_q <= SEPARATOR_RESET;
      protect_q   <= PROTECT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SEPARATOR: separator_q <= cfg_data_i;
        REG_PROTECT:   protect_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  csvt_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item),
    .in_stall_o  (in_stall_o),
    .take_i      (free),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  csvt_parser #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .separator_i (separator_q),
    .protect_i   (protect_q),
    .fire_i      (fire),
    .item_i      (item),
    .has_result_o(has_result),
    .result_o    (result)
  );

  csvt_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire && has_result),
    .result_i   (result),
    .free_o     (free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (out_result)
  );

  assign out_byte_o     = out_result.out_byte;
  assign byte_valid_o   = out_result.byte_valid;
  assign field_end_o    = out_result.field_end;
  assign row_end_o      = out_result.row_end;
  assign column_index_o = out_result.column_index;
  assign status_o       = out_result.status;

`ifndef ASSERT_OFF
  // An error word is the last word ever delivered before reset.
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (status_o != STATUS_OK) |=> !out_valid_o)
    else $error("result delivered after error word");

  // A content byte never also closes a field or a row.
  a_byte_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> !field_end_o && !row_end_o
      && (status_o == STATUS_OK))
    else $error("content byte marked as field or row end");

  // Error words carry no content and no row end.
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_OK) |-> !row_end_o && !field_end_o)
    else $error("error word carries field or row end");

  // Input stalls only while a held word waits on a full result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");
`endif

endmodule

// File: rtl/csvt_in_reg.sv
// Input register of the CSV tokenizer: holds one accepted word until the
// parser takes it. Depends on csvt_pkg.
`timescale 1ns / 1ps

module csvt_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  csvt_pkg::csvt_item_t in_item_i,
  output logic               in_stall_o,
  input  logic               take_i,
  output logic               item_valid_o,
  output csvt_pkg::csvt_item_t item_o
);
  import csvt_pkg::*;

  logic       valid_q;
  csvt_item_t item_q;

  // Stall only while a held word is not taken this cycle.
  assign in_stall_o   = valid_q && !take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

// File: rtl/csvt_parser.sv
// Tokenizer state and per-word decision logic: quoting, doubled protect
// bytes, column counting and row checks. Depends on csvt_pkg.
`timescale 1ns / 1ps

module csvt_parser #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           separator_i,
  input  logic [7:0]           protect_i,
  input  logic                 fire_i,
  input  csvt_pkg::csvt_item_t item_i,
  output logic                 has_result_o,
  output csvt_pkg::csvt_result_t result_o
);
  import csvt_pkg::*;

  localparam int unsigned CW = $clog2(MAX_COLUMNS + 1);
  localparam logic [CW-1:0] MaxCol = CW'(MAX_COLUMNS);

  logic          quoted_q, quoted_d;
  logic          pending_q, pending_d;
  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] learned_q, learned_d;
  logic          first_q, first_d;
  logic          err_q, err_d;

  logic [CW-1:0]   limit;
  logic [CW+7:0]   col_ext;
  logic            quoted_eff;
  logic            field_done;
  logic [CW-1:0]   count;
  logic            is_prot;
  logic            is_sep;

  assign limit   = first_q ? MaxCol : learned_q;
  assign col_ext = {8'b0, col_q};
  assign is_prot = (item_i.in_byte == protect_i);
  assign is_sep  = (item_i.in_byte == separator_i);

  always_comb begin
    quoted_d     = quoted_q;
    pending_d    = pending_q;
    col_d        = col_q;
    learned_d    = learned_q;
    first_d      = first_q;
    err_d        = err_q;
    has_result_o = 1'b0;
    result_o     = '{out_byte: '0, byte_valid: 1'b0, field_end: 1'b0,
                     row_end: 1'b0, column_index: col_ext[7:0],
                     status: STATUS_OK};
    quoted_eff   = quoted_q && !pending_q;
    field_done   = !quoted_eff;
    count        = col_q + CW'(field_done);

    if (err_q) begin
      has_result_o = 1'b0;
    end else if (item_i.end_of_line) begin
      has_result_o = 1'b1;
      if (field_done && (col_q >= limit)) begin
        err_d           = 1'b1;
        result_o.status = STATUS_TOO_LONG;
      end else if (!first_q && (count != learned_q)) begin
        err_d           = 1'b1;
        result_o.status = STATUS_TOO_SHORT;
      end else begin
        if (first_q) begin
          learned_d = count;
          first_d   = 1'b0;
        end
        result_o.field_end = field_done;
        result_o.row_end   = 1'b1;
        col_d     = '0;
        quoted_d  = 1'b0;
        pending_d = 1'b0;
      end
    end else if (pending_q && is_prot) begin
      // Doubled protect: one literal protect byte, quotes stay open.
      pending_d           = 1'b0;
      has_result_o        = 1'b1;
      result_o.out_byte   = item_i.in_byte;
      result_o.byte_valid = 1'b1;
    end else if (quoted_eff) begin
      if (is_prot) begin
        pending_d = 1'b1;
      end else begin
        has_result_o        = 1'b1;
        result_o.out_byte   = item_i.in_byte;
        result_o.byte_valid = 1'b1;
      end
    end else begin
      // Outside quotes (a pending protect closes them here).
      pending_d = 1'b0;
      quoted_d  = 1'b0;
      if (is_sep) begin
        has_result_o = 1'b1;
        if (col_q >= limit) begin
          err_d           = 1'b1;
          result_o.status = STATUS_TOO_LONG;
        end else begin
          result_o.field_end = 1'b1;
          col_d              = col_q + CW'(1);
        end
      end else if (is_prot) begin
        quoted_d = 1'b1;
      end else begin
        has_result_o        = 1'b1;
        result_o.out_byte   = item_i.in_byte;
        result_o.byte_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quoted_q  <= 1'b0;
      pending_q <= 1'b0;
      col_q     <= '0;
      learned_q <= '0;
      first_q   <= 1'b1;
      err_q     <= 1'b0;
    end else if (fire_i) begin
      quoted_q  <= quoted_d;
      pending_q <= pending_d;
      col_q     <= col_d;
      learned_q <= learned_d;
      first_q   <= first_d;
      err_q     <= err_d;
    end
  end

endmodule

// File: rtl/csvt_out_reg.sv
// Result register of the CSV tokenizer: holds one result word until the
// sink takes it. Depends on csvt_pkg.
`timescale 1ns / 1ps

module csvt_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  csvt_pkg::csvt_result_t result_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output csvt_pkg::csvt_result_t result_o
);
  import csvt_pkg::*;

  logic         valid_q;
  csvt_result_t result_q;

  // Free when empty or when the held word leaves this cycle.
  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      result_q <= result_i;
    end
  end

endmodule
